// ===== hdl/crc_block_body_deframer_unit_defines.svh =====
// Assertion macros used by the deframer controller.
`ifndef CRC_BLOCK_BODY_DEFRAMER_UNIT_DEFINES_SVH
`define CRC_BLOCK_BODY_DEFRAMER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every clk edge out of reset.
`define CBD_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cbd assertion failed");

// Next-cycle implication, checked on every clk edge out of reset.
`define CBD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cbd assertion failed");

`endif

// ===== hdl/cbd_pkg.sv =====
`default_nettype none

package cbd_pkg;

  // Sizes
  localparam int MAX_BLOCK_BYTES = 32;
  localparam int HEADER_BYTES    = 13;
  localparam int HPOS_W          = 4;
  localparam int BSIZE_W         = 6;
  localparam int BUF_AW          = (MAX_BLOCK_BYTES > 1) ? $clog2(MAX_BLOCK_BYTES) : 1;
  localparam int POS_W           = $clog2(MAX_BLOCK_BYTES + 3);
  localparam int POS_INC_W       = POS_W + 1;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 16;

  // CRC-16/CCITT polynomial
  localparam logic [15:0] CRC_POLY = 16'h1021;

  // Register reset values
  localparam logic [BSIZE_W-1:0] RST_BLOCK_SIZE = 6'd32;
  localparam logic [15:0]        RST_MAGIC      = 16'h0000;
  localparam logic [7:0]         RST_VERSION    = 8'h00;
  localparam logic [15:0]        RST_CRC_SEED   = 16'hFFFF;

  localparam logic [15:0] CNT_MAX = 16'hFFFF;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE       = 2'd0,
    REG_EXPECTED_MAGIC   = 2'd1,
    REG_EXPECTED_VERSION = 2'd2,
    REG_CRC_SEED         = 2'd3
  } cfg_reg_t;

  // Result kinds
  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_body;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        block_end;
    logic        header_good;
    logic [7:0]  stream_number;
    logic [15:0] queue_ms;
    logic [15:0] encode_us;
    logic [15:0] air_ms;
    logic [15:0] blocks_seen;
    logic [15:0] blocks_failed;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic absorb;      // take the input byte
    logic emit_clr;    // rewind the emit index
    logic count_fail;  // bump the failed-block counter
    logic load_byte;   // load a payload byte into the output register
    logic load_sum;    // load the summary into the output register
    logic clear;       // return body state to its start values
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic blk_done;    // byte at the input completes a block
    logic crc_ok;      // finished block's CRC matches
    logic emit_last;   // emit index points at the last payload byte
    logic slot_free;   // output register can take a result this cycle
  } sts_t;

  // One byte through the MSB-first CRC register
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/cbd_ctrl.sv =====
`default_nettype none

`include "crc_block_body_deframer_unit_defines.svh"

module cbd_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic          in_eob,
  output logic               in_ready,
  input  wire cbd_pkg::sts_t sts,
  output cbd_pkg::cmd_t      cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_EMIT,
    S_SUM
  } state_t;

  state_t state_r, state_nxt;
  logic   last_r, last_nxt;

  assign in_ready = (state_r == S_IDLE);

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    last_nxt  = last_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.absorb = 1'b1;
          last_nxt   = in_eob;
          if (sts.blk_done) begin
            state_nxt = S_CHECK;
          end else if (in_eob) begin
            state_nxt = S_SUM;
          end
        end
      end
      S_CHECK: begin
        cmd.emit_clr   = 1'b1;
        cmd.count_fail = !sts.crc_ok;
        if (sts.crc_ok) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = last_r ? S_SUM : S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts.slot_free) begin
          cmd.load_byte = 1'b1;
          if (sts.emit_last) begin
            state_nxt = last_r ? S_SUM : S_IDLE;
          end
        end
      end
      S_SUM: begin
        if (sts.slot_free) begin
          cmd.load_sum = 1'b1;
          cmd.clear    = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  // At most one of absorb, payload-byte load and summary load happens in a cycle
  `CBD_ASSERT_SAME(a_one_action, 1'b1, $onehot0({cmd.absorb, cmd.load_byte, cmd.load_sum}))
  // A failed block never emits
  `CBD_ASSERT_NEXT(a_fail_no_emit, (state_r == S_CHECK) && !sts.crc_ok, state_r != S_EMIT)
  // Emission stops after the last byte of the block
  `CBD_ASSERT_NEXT(a_emit_stops,
    (state_r == S_EMIT) && sts.slot_free && sts.emit_last, state_r != S_EMIT)
  // A summary closes the body and reopens the input
  `CBD_ASSERT_NEXT(a_sum_to_idle, cmd.load_sum, state_r == S_IDLE)

endmodule

`default_nettype wire

// ===== hdl/cbd_datapath.sv =====
`default_nettype none

module cbd_datapath (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire cbd_pkg::in_item_t                 in_data,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [cbd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [cbd_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire cbd_pkg::cmd_t                     cmd,
  output cbd_pkg::sts_t                          sts,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output cbd_pkg::out_item_t                     out_data
);

  // Configuration
  logic [cbd_pkg::BSIZE_W-1:0] blk_size_r;
  logic [15:0]                 magic_r;
  logic [7:0]                  version_r;
  logic [15:0]                 seed_r;

  // Body state
  logic [cbd_pkg::HPOS_W-1:0]  hpos_r;
  logic [7:0]                  hdr_r [cbd_pkg::HEADER_BYTES];
  logic [cbd_pkg::POS_W-1:0]   pos_r;
  logic [15:0]                 crc_r;
  logic [15:0]                 stored_r;
  logic [15:0]                 seen_r;
  logic [15:0]                 failed_r;
  logic [7:0]                  buf_r [cbd_pkg::MAX_BLOCK_BYTES];
  logic [cbd_pkg::BUF_AW-1:0]  idx_r;
  logic                        out_valid_r;
  cbd_pkg::out_item_t          out_r;
  cbd_pkg::out_item_t          out_nxt;

  logic [cbd_pkg::BSIZE_W-1:0]   bs;
  logic                          hdr_done;
  logic [cbd_pkg::POS_INC_W-1:0] pos_inc;
  logic                          blk_done;
  logic [cbd_pkg::BUF_AW-1:0]    wr_idx;
  logic                          hdr_good;
  logic                          sum_valid;
  logic                          emit_last;
  logic                          slot_free;

  // Effective block size, saturated to the buffer depth
  assign bs = (blk_size_r > cbd_pkg::BSIZE_W'(cbd_pkg::MAX_BLOCK_BYTES))
            ? cbd_pkg::BSIZE_W'(cbd_pkg::MAX_BLOCK_BYTES) : blk_size_r;

  assign hdr_done = (hpos_r == cbd_pkg::HPOS_W'(cbd_pkg::HEADER_BYTES));
  assign pos_inc  = cbd_pkg::POS_INC_W'(pos_r) + cbd_pkg::POS_INC_W'(1);
  assign blk_done = hdr_done && (bs != '0) && (pos_r >= cbd_pkg::POS_W'(2)) &&
                    ((pos_inc >= cbd_pkg::POS_INC_W'(bs) + cbd_pkg::POS_INC_W'(2)) ||
                     (pos_inc >= cbd_pkg::POS_INC_W'(cbd_pkg::MAX_BLOCK_BYTES + 2)));
  assign wr_idx   = cbd_pkg::BUF_AW'(pos_r - cbd_pkg::POS_W'(2));

  assign emit_last = (cbd_pkg::BSIZE_W'(idx_r) + cbd_pkg::BSIZE_W'(1)) == bs;
  assign slot_free = !out_valid_r || out_ready;

  assign sum_valid = hdr_done && (bs != '0);
  assign hdr_good  = ({hdr_r[1], hdr_r[0]} == magic_r) && (hdr_r[2] == version_r) &&
                     ({hdr_r[5], hdr_r[4]} == 16'(bs));

  assign sts.blk_done  = blk_done;
  assign sts.crc_ok    = (crc_r == stored_r);
  assign sts.emit_last = emit_last;
  assign sts.slot_free = slot_free;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_size_r <= cbd_pkg::RST_BLOCK_SIZE;
      magic_r    <= cbd_pkg::RST_MAGIC;
      version_r  <= cbd_pkg::RST_VERSION;
      seed_r     <= cbd_pkg::RST_CRC_SEED;
    end else if (cfg_valid) begin
      case (cbd_pkg::cfg_reg_t'(cfg_index))
        cbd_pkg::REG_BLOCK_SIZE:       blk_size_r <= cfg_data[cbd_pkg::BSIZE_W-1:0];
        cbd_pkg::REG_EXPECTED_MAGIC:   magic_r    <= cfg_data;
        cbd_pkg::REG_EXPECTED_VERSION: version_r  <= cfg_data[7:0];
        cbd_pkg::REG_CRC_SEED:         seed_r     <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Header capture, block framing, CRC and counters
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      hpos_r   <= '0;
      pos_r    <= '0;
      crc_r    <= seed_r;
      stored_r <= '0;
      seen_r   <= '0;
      failed_r <= '0;
      for (int i = 0; i < cbd_pkg::HEADER_BYTES; i++) begin
        hdr_r[i] <= '0;
      end
    end else begin
      if (cmd.absorb) begin
        if (!hdr_done) begin
          hdr_r[hpos_r] <= in_data.data_byte;
          hpos_r        <= hpos_r + cbd_pkg::HPOS_W'(1);
        end else if (bs == '0) begin
          pos_r <= '0;
        end else if (pos_r == cbd_pkg::POS_W'(0)) begin
          stored_r <= {8'h00, in_data.data_byte};
          pos_r    <= cbd_pkg::POS_W'(1);
        end else if (pos_r == cbd_pkg::POS_W'(1)) begin
          stored_r[15:8] <= in_data.data_byte;
          crc_r          <= seed_r;
          pos_r          <= cbd_pkg::POS_W'(2);
        end else begin
          crc_r <= cbd_pkg::crc_byte(crc_r, in_data.data_byte);
          pos_r <= blk_done ? '0 : pos_inc[cbd_pkg::POS_W-1:0];
          if (blk_done && (seen_r != cbd_pkg::CNT_MAX)) begin
            seen_r <= seen_r + 16'd1;
          end
        end
      end
      if (cmd.count_fail && (failed_r != cbd_pkg::CNT_MAX)) begin
        failed_r <= failed_r + 16'd1;
      end
    end
  end

  // Payload buffer, written only while a block is being collected
  always_ff @(posedge clk) begin
    if (cmd.absorb && hdr_done && (bs != '0) && (pos_r >= cbd_pkg::POS_W'(2))) begin
      buf_r[wr_idx] <= in_data.data_byte;
    end
  end

  // Emit index
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.emit_clr) begin
      idx_r <= '0;
    end else if (cmd.load_byte) begin
      idx_r <= idx_r + cbd_pkg::BUF_AW'(1);
    end
  end

  // Output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_byte || cmd.load_sum) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Next output: a buffered payload byte or the body summary
  always_comb begin
    out_nxt = '0;
    if (cmd.load_byte) begin
      out_nxt.kind         = cbd_pkg::KIND_PAYLOAD;
      out_nxt.payload_byte = buf_r[idx_r];
      out_nxt.block_end    = emit_last;
    end else begin
      out_nxt.kind = cbd_pkg::KIND_SUMMARY;
      if (sum_valid) begin
        out_nxt.header_good   = hdr_good;
        out_nxt.stream_number = hdr_r[3];
        out_nxt.blocks_seen   = seen_r;
        out_nxt.blocks_failed = failed_r;
        if (hdr_good) begin
          out_nxt.queue_ms  = {hdr_r[8], hdr_r[7]};
          out_nxt.encode_us = {hdr_r[10], hdr_r[9]};
          out_nxt.air_ms    = {hdr_r[12], hdr_r[11]};
        end
      end
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (cmd.load_byte || cmd.load_sum) begin
      out_r <= out_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/crc_block_body_deframer_unit.sv =====
// Block-body deframer with CRC-16/CCITT checking. Bytes of a body enter one per
// transfer, end_of_body marking the last. The first 13 bytes are a little-endian
// header (magic, version, stream id, block size, timing words); the rest is cut
// into blocks of a 16-bit CRC plus block_size payload bytes, and a block whose CRC
// matches is sent out byte by byte, then a summary closes each body. The input is
// held while the controller checks a completed block and sends its payload through
// the single output register, which carries one result per cycle when not stalled,
// and while it loads the summary after the last byte of a body. Output stalls hold
// the controller in those steps. Configuration is taken every cycle and applies to
// later bytes.
`default_nettype none

module crc_block_body_deframer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire cbd_pkg::in_item_t              in_data,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output cbd_pkg::out_item_t                  out_data,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cbd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cbd_pkg::CFG_DATA_W-1:0] cfg_data
);

  cbd_pkg::cmd_t cmd;
  cbd_pkg::sts_t sts;

  // Sequencer
  cbd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_eob   (in_data.end_of_body),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Framing, CRC, buffer and output register
  cbd_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
